[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

[sv/cofa_pkg.sv]
// ----------------------------------------------------------------------------
// cofa_pkg
// types, constants and control store of the operand fetch sequencer
// ----------------------------------------------------------------------------
package cofa_pkg;

   localparam int MEM_AW    = 16;
   localparam int MEM_DEPTH = 65536;
   localparam int UPC_W     = 5;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   localparam logic [3:0] MODE_DIRECT = 4'd0;
   localparam logic [3:0] MODE_IMM    = 4'd1;
   localparam logic [3:0] MODE_ZP     = 4'd2;
   localparam logic [3:0] MODE_ZPX    = 4'd3;
   localparam logic [3:0] MODE_ZPY    = 4'd4;
   localparam logic [3:0] MODE_INDX   = 4'd5;
   localparam logic [3:0] MODE_INDY   = 4'd6;
   localparam logic [3:0] MODE_ABS    = 4'd7;
   localparam logic [3:0] MODE_ABSX   = 4'd8;
   localparam logic [3:0] MODE_ABSY   = 4'd9;

   localparam logic [7:0] ZERO_PAGE = 8'h00;

   // control store entry points
   localparam logic [UPC_W-1:0] UA_EMIT   = 5'd0;
   localparam logic [UPC_W-1:0] UA_EMIT0  = 5'd1;
   localparam logic [UPC_W-1:0] UA_WRITE  = 5'd2;
   localparam logic [UPC_W-1:0] UA_DIRECT = 5'd3;
   localparam logic [UPC_W-1:0] UA_ZP     = 5'd4;
   localparam logic [UPC_W-1:0] UA_ZPX    = 5'd6;
   localparam logic [UPC_W-1:0] UA_ZPY    = 5'd8;
   localparam logic [UPC_W-1:0] UA_INDX   = 5'd10;
   localparam logic [UPC_W-1:0] UA_INDY   = 5'd14;
   localparam logic [UPC_W-1:0] UA_ABS    = 5'd18;
   localparam logic [UPC_W-1:0] UA_ABSX   = 5'd21;
   localparam logic [UPC_W-1:0] UA_ABSY   = 5'd24;
   localparam logic [UPC_W-1:0] UA_LAST   = 5'd26;

   typedef enum logic [2:0] {
      AS_ADDR  = 3'd0,
      AS_ADDR1 = 3'd1,
      AS_ZP    = 3'd2,
      AS_ZP1   = 3'd3,
      AS_WORD  = 3'd4
   } asel_type;

   typedef enum logic [1:0] {
      IX_NONE = 2'd0,
      IX_X    = 2'd1,
      IX_Y    = 2'd2
   } isel_type;

   typedef enum logic [1:0] {
      TA_HOLD  = 2'd0,
      TA_RDATA = 2'd1,
      TA_ALOW  = 2'd2
   } tasel_type;

   typedef enum logic [1:0] {
      SQ_NEXT = 2'd0,
      SQ_GOTO = 2'd1,
      SQ_END  = 2'd2,
      SQ_WAIT = 2'd3
   } seq_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef struct packed {
      logic             rd;
      logic             wr;
      asel_type         asel;
      isel_type         isel;
      tasel_type        tasel;
      logic             emit;
      logic             emit0;
      seq_type          seq;
      logic [UPC_W-1:0] jaddr;
   } uword_type;

   // strobes handed from sequencer to datapath
   typedef struct packed {
      logic      rd;
      logic      wr;
      asel_type  asel;
      isel_type  isel;
      tasel_type tasel;
      logic      emit;
      logic      emit0;
   } ctrl_type;

   function automatic uword_type uw(input logic rd, input logic wr, input asel_type asel,
                                    input isel_type isel, input tasel_type tasel,
                                    input logic emit, input logic emit0,
                                    input seq_type seq, input logic [UPC_W-1:0] jaddr);
      uword_type w;
      w.rd    = rd;
      w.wr    = wr;
      w.asel  = asel;
      w.isel  = isel;
      w.tasel = tasel;
      w.emit  = emit;
      w.emit0 = emit0;
      w.seq   = seq;
      w.jaddr = jaddr;
      return w;
   endfunction

   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] upc);
      uword_type w;
      case (upc)
         // result steps, which wait on a full output register, and the write step
         5'd0:  w = uw(1'b0, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b1, 1'b0, SQ_WAIT, UA_EMIT);
         5'd1:  w = uw(1'b0, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b1, SQ_WAIT, UA_EMIT0);
         5'd2:  w = uw(1'b0, 1'b1, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_END, UA_EMIT);
         // direct and immediate
         5'd3:  w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         // zero page
         5'd4:  w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd5:  w = uw(1'b1, 1'b0, AS_ZP, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         5'd6:  w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd7:  w = uw(1'b1, 1'b0, AS_ZP, IX_X, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         5'd8:  w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd9:  w = uw(1'b1, 1'b0, AS_ZP, IX_Y, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         // indexed indirect
         5'd10: w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd11: w = uw(1'b1, 1'b0, AS_ZP, IX_X, TA_ALOW, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd12: w = uw(1'b1, 1'b0, AS_ZP1, IX_NONE, TA_RDATA, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd13: w = uw(1'b1, 1'b0, AS_WORD, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         // indirect indexed
         5'd14: w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd15: w = uw(1'b1, 1'b0, AS_ZP, IX_NONE, TA_ALOW, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd16: w = uw(1'b1, 1'b0, AS_ZP1, IX_NONE, TA_RDATA, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd17: w = uw(1'b1, 1'b0, AS_WORD, IX_Y, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         // absolute
         5'd18: w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd19: w = uw(1'b1, 1'b0, AS_ADDR1, IX_NONE, TA_RDATA, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd20: w = uw(1'b1, 1'b0, AS_WORD, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         5'd21: w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd22: w = uw(1'b1, 1'b0, AS_ADDR1, IX_NONE, TA_RDATA, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd23: w = uw(1'b1, 1'b0, AS_WORD, IX_X, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         5'd24: w = uw(1'b1, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd25: w = uw(1'b1, 1'b0, AS_ADDR1, IX_NONE, TA_RDATA, 1'b0, 1'b0, SQ_NEXT, UA_EMIT);
         5'd26: w = uw(1'b1, 1'b0, AS_WORD, IX_Y, TA_HOLD, 1'b0, 1'b0, SQ_GOTO, UA_EMIT);
         default: w = uw(1'b0, 1'b0, AS_ADDR, IX_NONE, TA_HOLD, 1'b0, 1'b0, SQ_END, UA_EMIT);
      endcase
      return w;
   endfunction

   function automatic logic [UPC_W-1:0] entry_point(input logic func, input logic [3:0] mode);
      logic [UPC_W-1:0] e;
      if (func == FUNC_WRITE) begin
         e = UA_WRITE;
      end else begin
         case (mode)
            MODE_DIRECT: e = UA_DIRECT;
            MODE_IMM:    e = UA_DIRECT;
            MODE_ZP:     e = UA_ZP;
            MODE_ZPX:    e = UA_ZPX;
            MODE_ZPY:    e = UA_ZPY;
            MODE_INDX:   e = UA_INDX;
            MODE_INDY:   e = UA_INDY;
            MODE_ABS:    e = UA_ABS;
            MODE_ABSX:   e = UA_ABSX;
            MODE_ABSY:   e = UA_ABSY;
            default:     e = UA_EMIT0;
         endcase
      end
      return e;
   endfunction

endpackage

[sv/cpu_operand_fetch_addressing_top.sv]
// ----------------------------------------------------------------------------
// cpu_operand_fetch_addressing_top
// operand fetch with 6502-style addressing over a 64 KiB byte memory
// ----------------------------------------------------------------------------
// One item at a time: a beat is taken only while idle, then a microprogram walks
// the addressing chain through the single-port memory, one read per cycle.
// A write needs no read and sends no result; an undefined mode needs no read
// and returns zero; direct and immediate need one read, zero page (plain or
// indexed) two, absolute (plain or indexed) three and both indirect modes four.
// A result beat waits on rsp_tready; each read in a chain depends on the last.
// Memory contents are undefined until written; no clearing takes place.
// ----------------------------------------------------------------------------
module cpu_operand_fetch_addressing_top
   import cofa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // addr[15:0], index_x, index_y, wdata
   input  logic [4:0]  req_tuser,  // func, mode[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // operand
);

   logic     req_accept;
   logic     out_full;
   ctrl_type ctrl;

   assign req_accept = req_tvalid && req_tready;

   cofa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_accept(req_accept),
      .req_func  (req_tuser[0]),
      .req_mode  (req_tuser[4:1]),
      .out_full  (out_full),
      .ready     (req_tready),
      .ctrl      (ctrl)
   );

   cofa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_addr   (req_tdata[15:0]),
      .req_index_x(req_tdata[23:16]),
      .req_index_y(req_tdata[31:24]),
      .req_wdata  (req_tdata[39:32]),
      .ctrl       (ctrl),
      .out_full   (out_full),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_operand(rsp_tdata)
   );

endmodule

[sv/cofa_ram.sv]
// ----------------------------------------------------------------------------
// cofa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module cofa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/cofa_seq.sv]
// ----------------------------------------------------------------------------
// cofa_seq
// microprogram sequencer: step counter, control store and jump logic
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cofa_seq
   import cofa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_accept,
   input  logic       req_func,
   input  logic [3:0] req_mode,
   input  logic       out_full,
   output logic       ready,
   output ctrl_type   ctrl
);

   state_type        state_ff, state_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        uword;
   logic             stall;
   logic             exec;

   assign uword = ucode_rom(upc_ff);
   assign stall = (uword.seq == SQ_WAIT) && out_full;
   assign exec  = (state_ff == ST_RUN) && !stall;
   assign ready = (state_ff == ST_IDLE);

   assign ctrl.rd    = exec && uword.rd;
   assign ctrl.wr    = exec && uword.wr;
   assign ctrl.asel  = uword.asel;
   assign ctrl.isel  = uword.isel;
   assign ctrl.tasel = exec ? uword.tasel : TA_HOLD;
   assign ctrl.emit  = exec && uword.emit;
   assign ctrl.emit0 = exec && uword.emit0;

   always_comb begin
      state_in = state_ff;
      upc_in   = upc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_RUN;
               upc_in   = entry_point(req_func, req_mode);
            end
         end
         ST_RUN: begin
            case (uword.seq)
               SQ_NEXT: upc_in = upc_ff + 1'b1;
               SQ_GOTO: upc_in = uword.jaddr;
               SQ_END:  state_in = ST_IDLE;
               SQ_WAIT: begin
                  if (stall) begin
                     upc_in = uword.jaddr;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         upc_ff   <= UA_EMIT;
      end else begin
         state_ff <= state_in;
         upc_ff   <= upc_in;
      end
   end

   `ASSERT_CLK(a_accept_runs, clock, reset, req_accept |=> (state_ff == ST_RUN))
   `ASSERT_NEVER(a_rd_and_wr, clock, reset, ctrl.rd && ctrl.wr)
   `ASSERT_CLK(a_upc_in_program, clock, reset, (state_ff == ST_RUN) |-> (upc_ff <= UA_LAST))

endmodule

[sv/cofa_dp.sv]
// ----------------------------------------------------------------------------
// cofa_dp
// address datapath, byte memory and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cofa_dp
   import cofa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_accept,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_index_x,
   input  logic [7:0]  req_index_y,
   input  logic [7:0]  req_wdata,
   input  ctrl_type    ctrl,
   output logic        out_full,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_operand
);

   logic [15:0] addr_ff;
   logic [7:0]  x_ff;
   logic [7:0]  y_ff;
   logic [7:0]  wdata_ff;
   logic [7:0]  ta_ff, ta_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [7:0]  idx;
   logic [15:0] mem_addr;
   logic [7:0]  rdata;

   always_comb begin
      case (ctrl.isel)
         IX_X:    idx = x_ff;
         IX_Y:    idx = y_ff;
         default: idx = 8'h00;
      endcase
   end

   always_comb begin
      case (ctrl.asel)
         AS_ADDR:  mem_addr = addr_ff;
         AS_ADDR1: mem_addr = addr_ff + 16'd1;
         AS_ZP:    mem_addr = {ZERO_PAGE, rdata + idx};
         AS_ZP1:   mem_addr = {ZERO_PAGE, ta_ff + 8'd1};
         AS_WORD:  mem_addr = {rdata, ta_ff} + {8'h00, idx};
         default:  mem_addr = addr_ff;
      endcase
   end

   always_comb begin
      case (ctrl.tasel)
         TA_RDATA: ta_in = rdata;
         TA_ALOW:  ta_in = mem_addr[7:0];
         default:  ta_in = ta_ff;
      endcase
   end

   cofa_ram #(
      .WIDTH(8),
      .DEPTH(MEM_DEPTH)
   ) u_mem (
      .clock(clock),
      .en   (ctrl.rd || ctrl.wr),
      .we   (ctrl.wr),
      .addr (mem_addr[MEM_AW-1:0]),
      .wdata(wdata_ff),
      .rdata(rdata)
   );

   assign out_full = rsp_valid_ff && !rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.emit || ctrl.emit0) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ctrl.emit ? rdata : 8'h00;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff  <= req_addr;
         x_ff     <= req_index_x;
         y_ff     <= req_index_y;
         wdata_ff <= req_wdata;
      end
      ta_ff       <= ta_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_operand = rsp_data_ff;

   `ASSERT_NEVER(a_emit_on_full, clock, reset, (ctrl.emit || ctrl.emit0) && out_full)
   `ASSERT_CLK(a_valid_from_emit, clock, reset,
      $rose(rsp_valid_ff) |-> $past(ctrl.emit || ctrl.emit0))
   `ASSERT_CLK(a_stalled_beat_holds, clock, reset,
      $past(out_full) |-> (rsp_valid_ff && $stable(rsp_data_ff)))

endmodule
